// ===== hw/rtl/bws_pkg.sv =====
// bws_pkg: shared state type and fixed constants of the boolean walsh spectrum unit
// used by boolean_walsh_spectrum_unit; no dependencies

package bws_pkg;

	// width of the num_vars register and its value after reset
	localparam int unsigned CFG_W          = 3;
	localparam logic [CFG_W-1:0] NUM_VARS_RESET = 3'd4;

	// sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_BF_RD,
		ST_BF_WR,
		ST_BF_FLUSH,
		ST_EM_RD,
		ST_EM_OUT
	} state_t;

endpackage

// ===== hw/rtl/boolean_walsh_spectrum_unit.sv =====
// boolean_walsh_spectrum_unit: truth table load, in-place fast walsh-hadamard
// transform in one ram, and coefficient emission; uses bws_pkg and bws_ram
//
//  channel   signals                                   direction  moves
//  -------   ---------------------------------------   ---------  ------------------------
//  cfg       cfg_we, cfg_wdata                         in         num_vars write, no wait
//  in        in_valid, in_ready, func_bit              in         one truth table bit
//  out       out_valid, out_ready, spec_index,         out        one walsh coefficient
//            coefficient, last_coeff
//
// with N = 2^k table entries, a load takes N transfers at one per cycle, then the
// transform runs k passes in which every butterfly needs two ram writes through the
// single write port, plus a flush state to drain the last difference of a pass.
// emission gives the N coefficients in index order; a stalled output holds its
// register and the ram read address. no clearing pass follows reset: the ram is
// always fully written by a load before the transform reads it. a num_vars write
// abandons a partial load. the next load is taken while the last coefficient waits.

module boolean_walsh_spectrum_unit #(
	parameter int unsigned MAX_VARS = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [bws_pkg::CFG_W-1:0]           cfg_wdata,
	// truth table input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func_bit,
	// spectrum output
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [MAX_VARS-1:0]                 spec_index,
	output logic signed [MAX_VARS+1:0]          coefficient,
	output logic                                last_coeff
);

	localparam int unsigned IDX_W  = MAX_VARS;
	localparam int unsigned DATA_W = MAX_VARS + 2;
	localparam int unsigned DEPTH  = 1 << MAX_VARS;
	localparam logic [DATA_W-1:0] SIGN_POS = DATA_W'(1);
	localparam logic [DATA_W-1:0] SIGN_NEG = {DATA_W{1'b1}};

	bws_pkg::state_t state_q, state_nxt;

	logic [bws_pkg::CFG_W-1:0] num_vars_q;
	logic [bws_pkg::CFG_W-1:0] k_eff;
	logic [IDX_W-1:0]          size_mask;
	logic [IDX_W-1:0]          half_mask;

	logic [IDX_W-1:0]          load_cnt_q;
	logic [bws_pkg::CFG_W-1:0] pass_q;
	logic [IDX_W-1:0]          pair_q;
	logic [IDX_W-1:0]          emit_q;

	logic [IDX_W-1:0]          bit_sel;
	logic [IDX_W-1:0]          low_mask;
	logic [IDX_W-1:0]          lo_addr;
	logic [IDX_W-1:0]          hi_addr;
	logic [IDX_W-1:0]          lo_s1;
	logic [IDX_W-1:0]          hi_s1;

	logic                      pend_q;
	logic [IDX_W-1:0]          pend_addr_q;
	logic [DATA_W-1:0]         pend_data_q;

	logic                      ram_we;
	logic [IDX_W-1:0]          ram_waddr;
	logic [DATA_W-1:0]         ram_wdata;
	logic [IDX_W-1:0]          ram_raddr_a;
	logic [IDX_W-1:0]          ram_raddr_b;
	logic [DATA_W-1:0]         ram_rdata_a;
	logic [DATA_W-1:0]         ram_rdata_b;

	logic                      in_xfer;
	logic                      out_load;
	logic                      last_pass;

	logic                      out_valid_q;
	logic [IDX_W-1:0]          spec_index_q;
	logic [DATA_W-1:0]         coeff_q;
	logic                      last_q;

	// effective variable count: zero acts as one, anything above the max is clipped
	always_comb begin
		if (num_vars_q == '0) begin
			k_eff = bws_pkg::CFG_W'(1);
		end else if (num_vars_q > bws_pkg::CFG_W'(MAX_VARS)) begin
			k_eff = bws_pkg::CFG_W'(MAX_VARS);
		end else begin
			k_eff = num_vars_q;
		end
	end

	assign size_mask = ~({IDX_W{1'b1}} << k_eff);
	assign half_mask = size_mask >> 1;
	assign last_pass = (pass_q == k_eff - bws_pkg::CFG_W'(1));

	// butterfly pair addresses: insert a zero at the pass bit of the pair counter
	assign bit_sel  = IDX_W'(1) << pass_q;
	assign low_mask = bit_sel - IDX_W'(1);
	assign lo_addr  = ((pair_q & ~low_mask) << 1) | (pair_q & low_mask);
	assign hi_addr  = lo_addr | bit_sel;

	assign in_xfer = in_valid && in_ready;

	// sign and butterfly store
	bws_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bws_pkg::ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state, ram control and handshake
	always_comb begin
		state_nxt   = state_q;
		ram_we      = 1'b0;
		ram_waddr   = lo_s1;
		ram_wdata   = '0;
		ram_raddr_a = lo_addr;
		ram_raddr_b = hi_addr;
		in_ready    = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			bws_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ram_we    = 1'b1;
					ram_waddr = load_cnt_q;
					ram_wdata = func_bit ? SIGN_NEG : SIGN_POS;
					if (load_cnt_q == size_mask) begin
						state_nxt = bws_pkg::ST_BF_RD;
					end
				end
			end
			bws_pkg::ST_BF_RD: begin
				// difference of the previous butterfly goes back while this pair is read
				if (pend_q) begin
					ram_we    = 1'b1;
					ram_waddr = pend_addr_q;
					ram_wdata = pend_data_q;
				end
				state_nxt = bws_pkg::ST_BF_WR;
			end
			bws_pkg::ST_BF_WR: begin
				ram_we    = 1'b1;
				ram_waddr = lo_s1;
				ram_wdata = ram_rdata_a + ram_rdata_b;
				if (pair_q == half_mask) begin
					state_nxt = bws_pkg::ST_BF_FLUSH;
				end else begin
					state_nxt = bws_pkg::ST_BF_RD;
				end
			end
			bws_pkg::ST_BF_FLUSH: begin
				// drain the last difference before the next pass reads
				ram_we    = 1'b1;
				ram_waddr = pend_addr_q;
				ram_wdata = pend_data_q;
				if (last_pass) begin
					state_nxt = bws_pkg::ST_EM_RD;
				end else begin
					state_nxt = bws_pkg::ST_BF_RD;
				end
			end
			bws_pkg::ST_EM_RD: begin
				ram_raddr_a = emit_q;
				state_nxt   = bws_pkg::ST_EM_OUT;
			end
			bws_pkg::ST_EM_OUT: begin
				out_load    = !out_valid_q || out_ready;
				ram_raddr_a = out_load ? emit_q + IDX_W'(1) : emit_q;
				if (out_load && emit_q == size_mask) begin
					state_nxt = bws_pkg::ST_LOAD;
				end
			end
			default: begin
				state_nxt = bws_pkg::ST_LOAD;
			end
		endcase
	end

	// configuration and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vars_q <= bws_pkg::NUM_VARS_RESET;
			load_cnt_q <= '0;
			pass_q     <= '0;
			pair_q     <= '0;
			emit_q     <= '0;
			pend_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_vars_q <= cfg_wdata;
				load_cnt_q <= '0;
			end else if (in_xfer) begin
				load_cnt_q <= (load_cnt_q == size_mask) ? '0 : load_cnt_q + IDX_W'(1);
			end
			case (state_q)
				bws_pkg::ST_LOAD: begin
					pass_q <= '0;
					pair_q <= '0;
					emit_q <= '0;
					pend_q <= 1'b0;
				end
				bws_pkg::ST_BF_RD: begin
					pend_q <= 1'b0;
				end
				bws_pkg::ST_BF_WR: begin
					pend_q <= 1'b1;
					pair_q <= (pair_q == half_mask) ? '0 : pair_q + IDX_W'(1);
				end
				bws_pkg::ST_BF_FLUSH: begin
					pend_q <= 1'b0;
					pass_q <= pass_q + bws_pkg::CFG_W'(1);
				end
				bws_pkg::ST_EM_OUT: begin
					if (out_load) begin
						emit_q <= emit_q + IDX_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// butterfly address and difference registers
	always_ff @(posedge clk) begin
		if (state_q == bws_pkg::ST_BF_RD) begin
			lo_s1 <= lo_addr;
			hi_s1 <= hi_addr;
		end
		if (state_q == bws_pkg::ST_BF_WR) begin
			pend_addr_q <= hi_s1;
			pend_data_q <= ram_rdata_a - ram_rdata_b;
		end
	end

	// output register, parts the ram read from the output stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			spec_index_q <= emit_q;
			coeff_q      <= ram_rdata_a;
			last_q       <= (emit_q == size_mask);
		end
	end

	assign out_valid   = out_valid_q;
	assign spec_index  = spec_index_q;
	assign coefficient = coeff_q;
	assign last_coeff  = last_q;

`ifndef SYNTH
	// the store is never written while the spectrum is read out
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bws_pkg::ST_EM_RD || state_q == bws_pkg::ST_EM_OUT) |-> !ram_we)
		else $error("ram write during emission");

	// a pending difference is only ever drained in a read or flush cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == bws_pkg::ST_BF_RD || state_q == bws_pkg::ST_BF_FLUSH))
		else $error("pending butterfly result in wrong state");

	// the transform never runs past its last pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bws_pkg::ST_BF_RD || state_q == bws_pkg::ST_BF_WR) |-> pass_q < k_eff)
		else $error("pass counter beyond variable count");

	// the final coefficient carries the top index of the table
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> spec_index_q == size_mask)
		else $error("last coefficient at wrong index");

	// the end of a load always starts the transform
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !cfg_we && load_cnt_q == size_mask) |=> state_q == bws_pkg::ST_BF_RD)
		else $error("transform not started after full load");
`endif

endmodule

// ===== hw/rtl/bws_ram.sv =====
// bws_ram: generic synchronous ram, one write port and two registered read ports
// no dependencies

module bws_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns old data on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== tb/boolean_walsh_spectrum_unit_test.sv =====
// boolean_walsh_spectrum_unit_test: self-checking bench for the walsh spectrum unit
// loads truth tables, predicts every coefficient and compares each output transfer
// depends on bws_pkg and boolean_walsh_spectrum_unit

module boolean_walsh_spectrum_unit_test;

	localparam int unsigned VARS_MAX      = 6;
	localparam int unsigned SETTLE_CYCLES = 32;   // block is idle well within this once drained
	localparam int unsigned HOLD_CYCLES   = 400;  // long output hold-off, longer than any spectrum
	localparam int unsigned RANDOM_BITS   = 175;

	// shapes of truth table used by the stimulus
	typedef enum int {
		FORM_NOISE,
		FORM_LINEAR,
		FORM_FLAT,
		FORM_SPARSE
	} form_t;

	// predictor and expected coefficient store
	class walsh_spectrum_book;
		typedef struct packed {
			logic [VARS_MAX-1:0]        idx;
			logic signed [VARS_MAX+1:0] coef;
			logic                       last;
		} coeff_t;

		logic signed [7:0]         signs [64];
		int unsigned               fill;
		logic [bws_pkg::CFG_W-1:0] vars;
		coeff_t                    coeffs_owed [$];
		int unsigned               faults;

		function new();
			fill   = 0;
			vars   = bws_pkg::NUM_VARS_RESET;
			faults = 0;
		endfunction

		// out-of-range counts are clamped to 1..VARS_MAX
		function int unsigned table_size();
			int unsigned k;
			k = vars;
			if (k < 1) k = 1;
			if (k > VARS_MAX) k = VARS_MAX;
			return 1 << k;
		endfunction

		// any write abandons a partial load
		function void set_vars(logic [bws_pkg::CFG_W-1:0] v);
			vars = v;
			fill = 0;
		endfunction

		// note one accepted truth table bit; a full table yields the whole spectrum
		function void take_bit(logic b);
			int unsigned n, i, j;
			int          sum;
			logic [5:0]  common;
			coeff_t      c;
			n = table_size();
			if (fill >= n) fill = 0;
			signs[fill] = b ? -8'sd1 : 8'sd1;
			fill++;
			if (fill < n) return;
			fill = 0;
			for (i = 0; i < n; i++) begin
				sum = 0;
				for (j = 0; j < n; j++) begin
					common = i[5:0] & j[5:0];
					sum += (^common) ? -signs[j] : signs[j];
				end
				c.idx  = i[VARS_MAX-1:0];
				c.coef = sum[VARS_MAX+1:0];
				c.last = (i == n - 1);
				coeffs_owed = {coeffs_owed, c};
			end
		endfunction

		// compare one output transfer with the oldest expectation
		function void match_coeff(logic [VARS_MAX-1:0] idx, logic signed [VARS_MAX+1:0] coef,
				logic last);
			coeff_t want;
			if (coeffs_owed.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected coefficient: index %0d value %0d last %0d",
						idx, coef, last);
				return;
			end
			want = coeffs_owed.pop_front();
			if (want.idx !== idx || want.coef !== coef || want.last !== last) begin
				faults++;
				if (faults <= 10)
					$display("coefficient mismatch: expected index %0d value %0d last %0d,",
						want.idx, want.coef, want.last,
						" got index %0d value %0d last %0d", idx, coef, last);
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n    = 1'b0;
	logic                        cfg_we    = 1'b0;
	logic [bws_pkg::CFG_W-1:0]   cfg_wdata = '0;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	logic                        func_bit  = 1'b0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [VARS_MAX-1:0]         spec_index;
	logic signed [VARS_MAX+1:0]  coefficient;
	logic                        last_coeff;

	walsh_spectrum_book book = new();

	int unsigned bits_sent  = 0;
	int unsigned burst_left = 0;
	bit          hold_req   = 1'b0;

	boolean_walsh_spectrum_unit #(
		.MAX_VARS(VARS_MAX)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func_bit   (func_bit),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.spec_index (spec_index),
		.coefficient(coefficient),
		.last_coeff (last_coeff)
	);

	// 4-unit clock period
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// output side: every accepted transfer is checked at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.match_coeff(spec_index, coefficient, last_coeff);
	end

	// receiver: spans of always ready, mostly ready, or a rotating stall pattern,
	// with one long hold-off on request so the block backs up into its input
	initial begin : receiver
		int unsigned mode, span, hold;
		logic [7:0]  pat;
		hold = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(8, 40);
			pat  = 8'($urandom_range(1, 255));
			repeat (span) begin
				@(negedge clk);
				if (hold_req) begin
					hold_req = 1'b0;
					hold     = HOLD_CYCLES;
				end
				if (hold > 0) begin
					out_ready = 1'b0;
					hold--;
				end else begin
					case (mode)
						0: out_ready = 1'b1;
						1: out_ready = ($urandom_range(0, 3) != 0);
						default: begin
							out_ready = pat[0];
							pat       = {pat[0], pat[7:1]};
						end
					endcase
				end
			end
		end
	end

	// one truth table bit; the sender runs in bursts with random gaps in between
	task automatic send_bit(input logic b);
		int unsigned gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 16);
			repeat (gap) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
		end
		@(negedge clk);
		in_valid = 1'b1;
		func_bit = b;
		do @(posedge clk); while (!in_ready);
		book.take_bit(b);
		bits_sent++;
		burst_left--;
	endtask

	// stop offering, wait for every owed coefficient, then let the block settle
	task automatic drain();
		@(negedge clk);
		in_valid   = 1'b0;
		burst_left = 0;
		while (book.coeffs_owed.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only once the block has gone idle
	task automatic write_vars(input logic [bws_pkg::CFG_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		book.set_vars(v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// one full table of the given shape
	task automatic load_table(input int unsigned n, input form_t form, input logic [5:0] mask,
			input logic inv);
		int unsigned j;
		logic        b;
		for (j = 0; j < n; j++) begin
			case (form)
				FORM_NOISE:  b = 1'($urandom_range(0, 1));
				FORM_LINEAR: b = (^(mask & j[5:0])) ^ inv;
				FORM_FLAT:   b = inv;
				default:     b = ($urandom_range(0, 7) == 0);
			endcase
			send_bit(b);
		end
	endtask

	initial begin : stimulus
		int unsigned               phase, n, tables, t, random_start;
		logic [bws_pkg::CFG_W-1:0] v;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset width of four variables: complemented linear function, one peak of -16
		load_table(16, FORM_LINEAR, 6'd5, 1'b1);
		// single variable, both ones
		write_vars(3'd1);
		send_bit(1'b1);
		send_bit(1'b1);
		// zero variables behaves as one
		write_vars(3'd0);
		send_bit(1'b0);
		send_bit(1'b1);
		// a write during a load throws the partial table away
		write_vars(3'd2);
		send_bit(1'b1);
		write_vars(3'd2);
		send_bit(1'b0);
		send_bit(1'b1);
		send_bit(1'b1);
		send_bit(1'b0);

		// random phases; the first three force the extremes and the back-pressure case
		random_start = bits_sent;
		phase        = 0;
		while (bits_sent - random_start < RANDOM_BITS) begin
			if (phase == 0)
				v = 3'd7;
			else if (phase == 1)
				v = 3'd6;
			else if (phase == 2)
				v = 3'd3;
			else if ($urandom_range(0, 7) == 0)
				v = bws_pkg::CFG_W'($urandom_range(5, 7));
			else
				v = bws_pkg::CFG_W'($urandom_range(0, 4));
			write_vars(v);
			n      = book.table_size();
			tables = (phase == 2) ? 4 : (n >= 32) ? 1 : $urandom_range(1, 4);
			if (phase == 2)
				hold_req = 1'b1;
			for (t = 0; t < tables; t++) begin
				if (phase < 2)
					load_table(n, FORM_FLAT, 6'd0, (phase == 0));
				else
					load_table(n, form_t'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
						1'($urandom_range(0, 1)));
			end
			// broken sequence left behind for the next write to discard
			if (phase > 2 && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, n - 1)) send_bit(1'($urandom_range(0, 1)));
			phase++;
		end

		drain();
		if (book.faults == 0 && book.coeffs_owed.size() == 0)
			$display("boolean_walsh_spectrum_unit verification clean");
		else
			$display("boolean_walsh_spectrum_unit verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("boolean_walsh_spectrum_unit verification failed");
		$finish;
	end

endmodule
